FILE: design/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/ebarc_pkg.sv
// shared types, tables and helper functions of the record converter
`default_nettype none
package ebarc_pkg;

    localparam int C_MAX_RECORD = 4096;
    localparam int LW           = 17;   // width for length arithmetic
    localparam int BW           = 8;
    localparam int RW           = 13;
    localparam int TW           = 32;
    localparam int NRES         = 3;

    localparam logic [2:0] MODE_COPY  = 3'd0;
    localparam logic [2:0] MODE_E2A   = 3'd1;
    localparam logic [2:0] MODE_UNBLK = 3'd2;
    localparam logic [2:0] MODE_A2E   = 3'd3;
    localparam logic [2:0] MODE_A2IBM = 3'd4;
    localparam logic [2:0] MODE_BLK   = 3'd5;

    localparam logic [1:0] REG_CONV_MODE = 2'd0;
    localparam logic [1:0] REG_CASE_MODE = 2'd1;
    localparam logic [1:0] REG_REC_LEN   = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;

    // one classified item: up to three results plus the running count
    typedef struct packed {
        logic [1:0]                cnt;
        logic [NRES-1:0][BW-1:0]   val;
        logic [NRES-1:0][RW-1:0]   rep;
        logic [TW-1:0]             trunc;
    } t_cmd;

    localparam logic [7:0] E2A [256] = '{
        8'o000,8'o001,8'o002,8'o003,8'o234,8'o011,8'o206,8'o177,
        8'o227,8'o215,8'o216,8'o013,8'o014,8'o015,8'o016,8'o017,
        8'o020,8'o021,8'o022,8'o023,8'o235,8'o205,8'o010,8'o207,
        8'o030,8'o031,8'o222,8'o217,8'o034,8'o035,8'o036,8'o037,
        8'o200,8'o201,8'o202,8'o203,8'o204,8'o012,8'o027,8'o033,
        8'o210,8'o211,8'o212,8'o213,8'o214,8'o005,8'o006,8'o007,
        8'o220,8'o221,8'o026,8'o223,8'o224,8'o225,8'o226,8'o004,
        8'o230,8'o231,8'o232,8'o233,8'o024,8'o025,8'o236,8'o032,
        8'o040,8'o240,8'o241,8'o242,8'o243,8'o244,8'o245,8'o246,
        8'o247,8'o250,8'o133,8'o056,8'o074,8'o050,8'o053,8'o041,
        8'o046,8'o251,8'o252,8'o253,8'o254,8'o255,8'o256,8'o257,
        8'o260,8'o261,8'o135,8'o044,8'o052,8'o051,8'o073,8'o136,
        8'o055,8'o057,8'o262,8'o263,8'o264,8'o265,8'o266,8'o267,
        8'o270,8'o271,8'o174,8'o054,8'o045,8'o137,8'o076,8'o077,
        8'o272,8'o273,8'o274,8'o275,8'o276,8'o277,8'o300,8'o301,
        8'o302,8'o140,8'o072,8'o043,8'o100,8'o047,8'o075,8'o042,
        8'o303,8'o141,8'o142,8'o143,8'o144,8'o145,8'o146,8'o147,
        8'o150,8'o151,8'o304,8'o305,8'o306,8'o307,8'o310,8'o311,
        8'o312,8'o152,8'o153,8'o154,8'o155,8'o156,8'o157,8'o160,
        8'o161,8'o162,8'o313,8'o314,8'o315,8'o316,8'o317,8'o320,
        8'o321,8'o176,8'o163,8'o164,8'o165,8'o166,8'o167,8'o170,
        8'o171,8'o172,8'o322,8'o323,8'o324,8'o325,8'o326,8'o327,
        8'o330,8'o331,8'o332,8'o333,8'o334,8'o335,8'o336,8'o337,
        8'o340,8'o341,8'o342,8'o343,8'o344,8'o345,8'o346,8'o347,
        8'o173,8'o101,8'o102,8'o103,8'o104,8'o105,8'o106,8'o107,
        8'o110,8'o111,8'o350,8'o351,8'o352,8'o353,8'o354,8'o355,
        8'o175,8'o112,8'o113,8'o114,8'o115,8'o116,8'o117,8'o120,
        8'o121,8'o122,8'o356,8'o357,8'o360,8'o361,8'o362,8'o363,
        8'o134,8'o237,8'o123,8'o124,8'o125,8'o126,8'o127,8'o130,
        8'o131,8'o132,8'o364,8'o365,8'o366,8'o367,8'o370,8'o371,
        8'o060,8'o061,8'o062,8'o063,8'o064,8'o065,8'o066,8'o067,
        8'o070,8'o071,8'o372,8'o373,8'o374,8'o375,8'o376,8'o377
    };

    localparam logic [7:0] A2E [256] = '{
        8'o000,8'o001,8'o002,8'o003,8'o067,8'o055,8'o056,8'o057,
        8'o026,8'o005,8'o045,8'o013,8'o014,8'o015,8'o016,8'o017,
        8'o020,8'o021,8'o022,8'o023,8'o074,8'o075,8'o062,8'o046,
        8'o030,8'o031,8'o077,8'o047,8'o034,8'o035,8'o036,8'o037,
        8'o100,8'o117,8'o177,8'o173,8'o133,8'o154,8'o120,8'o175,
        8'o115,8'o135,8'o134,8'o116,8'o153,8'o140,8'o113,8'o141,
        8'o360,8'o361,8'o362,8'o363,8'o364,8'o365,8'o366,8'o367,
        8'o370,8'o371,8'o172,8'o136,8'o114,8'o176,8'o156,8'o157,
        8'o174,8'o301,8'o302,8'o303,8'o304,8'o305,8'o306,8'o307,
        8'o310,8'o311,8'o321,8'o322,8'o323,8'o324,8'o325,8'o326,
        8'o327,8'o330,8'o331,8'o342,8'o343,8'o344,8'o345,8'o346,
        8'o347,8'o350,8'o351,8'o112,8'o340,8'o132,8'o137,8'o155,
        8'o171,8'o201,8'o202,8'o203,8'o204,8'o205,8'o206,8'o207,
        8'o210,8'o211,8'o221,8'o222,8'o223,8'o224,8'o225,8'o226,
        8'o227,8'o230,8'o231,8'o242,8'o243,8'o244,8'o245,8'o246,
        8'o247,8'o250,8'o251,8'o300,8'o152,8'o320,8'o241,8'o007,
        8'o040,8'o041,8'o042,8'o043,8'o044,8'o025,8'o006,8'o027,
        8'o050,8'o051,8'o052,8'o053,8'o054,8'o011,8'o012,8'o033,
        8'o060,8'o061,8'o032,8'o063,8'o064,8'o065,8'o066,8'o010,
        8'o070,8'o071,8'o072,8'o073,8'o004,8'o024,8'o076,8'o341,
        8'o101,8'o102,8'o103,8'o104,8'o105,8'o106,8'o107,8'o110,
        8'o111,8'o121,8'o122,8'o123,8'o124,8'o125,8'o126,8'o127,
        8'o130,8'o131,8'o142,8'o143,8'o144,8'o145,8'o146,8'o147,
        8'o150,8'o151,8'o160,8'o161,8'o162,8'o163,8'o164,8'o165,
        8'o166,8'o167,8'o170,8'o200,8'o212,8'o213,8'o214,8'o215,
        8'o216,8'o217,8'o220,8'o232,8'o233,8'o234,8'o235,8'o236,
        8'o237,8'o240,8'o252,8'o253,8'o254,8'o255,8'o256,8'o257,
        8'o260,8'o261,8'o262,8'o263,8'o264,8'o265,8'o266,8'o267,
        8'o270,8'o271,8'o272,8'o273,8'o274,8'o275,8'o276,8'o277,
        8'o312,8'o313,8'o314,8'o315,8'o316,8'o317,8'o332,8'o333,
        8'o334,8'o335,8'o336,8'o337,8'o352,8'o353,8'o354,8'o355,
        8'o356,8'o357,8'o372,8'o373,8'o374,8'o375,8'o376,8'o377
    };

    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic [1:0] cm);
        logic [7:0] r;
        r = c;
        if (cm[1] && r >= 8'h61 && r <= 8'h7a) r = r - 8'h20;
        if (cm[0] && r >= 8'h41 && r <= 8'h5a) r = r + 8'h20;
        return r;
    endfunction

    function automatic logic [7:0] to_ebcdic(input logic [2:0] mode, input logic [7:0] c);
        logic [7:0] r;
        r = A2E[c];
        if (mode == MODE_BLK) begin
            r = c;
        end else if (mode == MODE_A2IBM) begin
            if (c == 8'd33)  r = 8'd90;
            if (c == 8'd91)  r = 8'd173;
            if (c == 8'd93)  r = 8'd189;
            if (c == 8'd124) r = 8'd79;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/ebarc_front.sv
// front end: config registers, record state and classification of each item
`default_nettype none
module ebarc_front
    import ebarc_pkg::*;
#(
    parameter int MAX_RECORD = C_MAX_RECORD
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);
    localparam int PW = $clog2(MAX_RECORD + 2);
    localparam logic [LW-1:0] MAXR = LW'(MAX_RECORD);

    logic [2:0]    r_conv;
    logic [1:0]    r_case;
    logic [12:0]   r_rlen;
    logic [PW-1:0] r_pos,   n_pos;
    logic [12:0]   r_pend,  n_pend;
    logic [TW-1:0] r_trunc, n_trunc;

    logic [LW-1:0] len, pos, pos_inc;
    logic [7:0]    c_unb, t_blk, sp_blk;
    logic          acc;
    t_cmd          cmd;

    assign acc     = i_valid && !i_full;
    assign o_ready = !i_full;
    assign o_push  = acc;
    assign o_cmd   = cmd;

    always_comb begin
        len     = (LW'(r_rlen) > MAXR) ? MAXR : LW'(r_rlen);
        pos     = LW'(r_pos);
        pos_inc = pos + 1'b1;
        c_unb   = (r_conv == MODE_E2A) ? E2A[i_byte] : i_byte;
        t_blk   = to_ebcdic(r_conv, fold_case(i_byte, r_case));
        sp_blk  = to_ebcdic(r_conv, CH_SPACE);
        n_pos   = r_pos;
        n_pend  = r_pend;
        n_trunc = r_trunc;
        cmd     = '0;
        if (r_conv == MODE_E2A || r_conv == MODE_UNBLK) begin
            if (len == '0) begin
                cmd.val[0] = fold_case(c_unb, r_case);
                cmd.rep[0] = RW'(1);
                cmd.cnt    = 2'd1;
            end else begin
                if (c_unb == CH_SPACE) begin
                    if (r_pend != 13'h1fff) n_pend = r_pend + 1'b1;
                end else begin
                    // flush held-back spaces before the visible byte
                    if (r_pend != '0) begin
                        cmd.val[0] = CH_SPACE;
                        cmd.rep[0] = r_pend;
                        cmd.cnt    = 2'd1;
                    end
                    n_pend = '0;
                    cmd.val[cmd.cnt] = fold_case(c_unb, r_case);
                    cmd.rep[cmd.cnt] = RW'(1);
                    cmd.cnt          = cmd.cnt + 1'b1;
                end
                n_pos = PW'(pos_inc);
                if (pos_inc >= len) begin
                    cmd.val[cmd.cnt] = CH_NL;
                    cmd.rep[cmd.cnt] = RW'(1);
                    cmd.cnt          = cmd.cnt + 1'b1;
                    n_pos  = '0;
                    n_pend = '0;
                end
            end
        end else if (r_conv == MODE_A2E || r_conv == MODE_A2IBM || r_conv == MODE_BLK) begin
            if (len == '0) begin
                cmd.val[0] = t_blk;
                cmd.rep[0] = RW'(1);
                cmd.cnt    = 2'd1;
            end else if (i_byte == CH_NL) begin
                if (pos < len) begin
                    cmd.val[0] = sp_blk;
                    cmd.rep[0] = RW'(len - pos);
                    cmd.cnt    = 2'd1;
                end
                n_pos = '0;
            end else if (pos < len) begin
                n_pos      = PW'(pos_inc);
                cmd.val[0] = t_blk;
                cmd.rep[0] = RW'(1);
                cmd.cnt    = 2'd1;
            end else if (pos == len) begin
                if (r_trunc != '1) n_trunc = r_trunc + 1'b1;
                n_pos = PW'(pos_inc);
            end
        end else begin
            cmd.val[0] = fold_case(i_byte, r_case);
            cmd.rep[0] = RW'(1);
            cmd.cnt    = 2'd1;
        end
        // nothing emitted: one empty result
        if (cmd.cnt == 2'd0) cmd.cnt = 2'd1;
        cmd.trunc = n_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv  <= MODE_COPY;
            r_case  <= '0;
            r_rlen  <= '0;
            r_pos   <= '0;
            r_pend  <= '0;
            r_trunc <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CONV_MODE: r_conv <= i_cfg_data[2:0];
                    REG_CASE_MODE: r_case <= i_cfg_data[1:0];
                    REG_REC_LEN:   r_rlen <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos   <= n_pos;
                r_pend  <= n_pend;
                r_trunc <= n_trunc;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/ebarc_queue.sv
// two-entry command queue between front and back
`default_nettype none
`include "assert_macros.svh"
module ebarc_queue
    import ebarc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))
    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)

endmodule
`default_nettype wire

FILE: design/ebarc_back.sv
// back end: walks the results of each command into the output register
`default_nettype none
`include "assert_macros.svh"
module ebarc_back
    import ebarc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  wire logic   i_tready,
    output logic        o_tvalid,
    output logic [55:0] o_tdata,
    output logic        o_tlast
);
    logic        r_valid;
    logic [55:0] r_data;
    logic        r_last;
    logic [1:0]  r_idx;
    logic        load, fin;

    assign load     = (!r_valid || i_tready) && !i_empty;
    assign fin      = (r_idx == i_cmd.cnt - 1'b1);
    assign o_pop    = load && fin;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {3'b000, i_cmd.trunc, i_cmd.rep[r_idx], i_cmd.val[r_idx]};
            r_last <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load)            r_valid <= 1'b1;
            else if (i_tready)   r_valid <= 1'b0;
            if (load) r_idx <= fin ? 2'd0 : r_idx + 1'b1;
        end
    end

    `ASSERT_ALWAYS(a_cnt_nonzero, i_clk, i_rst_n, i_empty || (i_cmd.cnt != 2'd0))
    `ASSERT_ALWAYS(a_idx_in_range, i_clk, i_rst_n, i_empty || (r_idx < i_cmd.cnt))
    `ASSERT_NEXT(a_idx_restart, i_clk, i_rst_n, o_pop, r_idx == 2'd0)

endmodule
`default_nettype wire

FILE: design/ebcdic_ascii_record_converter.sv
// top level of the ebcdic/ascii record converter
// Usage: one input byte per item on the s_axis channel (tdata[7:0] = in_byte).
// Each item yields one to three result items on m_axis; tdata carries
// out_byte [7:0], repeat_res [20:8], truncated_records [52:21], zero pad above;
// tlast marks the final result of an input byte. repeat_res 0 means no byte.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 conv_mode, 1 case_mode, 2 record_length); write only while idle.
// The first result of a byte is written into the command queue when the byte is
// accepted, then loaded into the output register, before it is valid on m_axis.
// Throughput: one result per cycle while m_axis_tready is high; the results of
// a byte that makes two or three leave the output stage one after another,
// buffered by a two-entry command queue so the front keeps accepting
// meanwhile until both queue entries are taken.
// Reset clears the configuration registers, record position, held spaces and the
// truncation count; no output is valid after reset.
// When the receiver drops tready the output register holds, the queue
// fills and s_axis_tready falls once both queue entries are taken.
`default_nettype none
module ebcdic_ascii_record_converter
    import ebarc_pkg::*;
#(
    parameter int MAX_RECORD = C_MAX_RECORD
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_byte, repeat_res, truncated_records
    output logic             m_axis_tlast
);
    logic push, pop, full, empty;
    t_cmd f_cmd, q_cmd;

    ebarc_front #(.MAX_RECORD(MAX_RECORD)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(s_axis_tvalid), .i_byte(s_axis_tdata), .i_full(full),
        .o_ready(s_axis_tready), .o_push(push), .o_cmd(f_cmd)
    );

    ebarc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(f_cmd), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_cmd(q_cmd)
    );

    ebarc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_cmd(q_cmd), .o_pop(pop),
        .i_tready(m_axis_tready), .o_tvalid(m_axis_tvalid),
        .o_tdata(m_axis_tdata), .o_tlast(m_axis_tlast)
    );

endmodule
`default_nettype wire
